### hdl/qzr_pkg.sv
// Shared types, constants and tables of the block quantizer / zigzag / run-length coder.
// Used by qzr_ctrl, qzr_datapath and the top level; depends on nothing else.
package qzr_pkg;

    localparam int COEF_BITS = 12;
    localparam int BLOCK_LEN = 64;
    localparam int POS_BITS  = $clog2(BLOCK_LEN);
    localparam int CNT_BITS  = POS_BITS + 1;
    localparam int QTAB_BITS = 7;

    // Rounded quotient = floor((2*|c| + d) / (2*d)), taken as a multiply by a
    // reciprocal. The numerator stays below 2^(COEF_BITS+1) and the doubled
    // divisor below 2^8, so a shift of COEF_BITS+9 makes the product exact.
    localparam int NUM_BITS    = COEF_BITS + 1;
    localparam int QUANT_SHIFT = COEF_BITS + 9;
    localparam int RECIP_BITS  = COEF_BITS + 5;
    localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;
    localparam int QUO_BITS    = PROD_BITS - QUANT_SHIFT;

    typedef int t_itab [BLOCK_LEN];

    localparam t_itab LUMA_Q = '{
        16, 11, 10, 16, 24, 40, 51, 61,
        12, 12, 14, 19, 26, 58, 60, 55,
        14, 13, 16, 24, 40, 57, 69, 56,
        14, 17, 22, 29, 51, 87, 80, 62,
        18, 22, 37, 56, 68, 109, 103, 77,
        24, 35, 55, 64, 81, 104, 113, 92,
        49, 64, 78, 87, 103, 121, 120, 101,
        72, 92, 95, 98, 112, 100, 103, 99
    };

    localparam t_itab CHROMA_Q = '{
        17, 18, 24, 47, 99, 99, 99, 99,
        18, 21, 26, 66, 99, 99, 99, 99,
        24, 26, 56, 99, 99, 99, 99, 99,
        47, 66, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99
    };

    // Row-major position to zigzag rank.
    localparam t_itab ZZ_RANK = '{
         0,  1,  5,  6, 14, 15, 27, 28,
         2,  4,  7, 13, 16, 26, 29, 42,
         3,  8, 12, 17, 25, 30, 41, 43,
         9, 11, 18, 24, 31, 40, 44, 53,
        10, 19, 23, 32, 39, 45, 52, 54,
        20, 22, 33, 38, 46, 51, 55, 60,
        21, 34, 37, 47, 50, 56, 59, 61,
        35, 36, 48, 49, 57, 58, 62, 63
    };

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_SCAN,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic                load;
        logic [POS_BITS-1:0] load_pos;
        logic                rd_en;
        logic [POS_BITS-1:0] rd_addr;
        logic                run_start;
        logic                run_inc;
        logic                emit;
        logic                emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic run_match;
        logic out_free;
    } t_dp_status;

endpackage

### hdl/qzr_datapath.sv
// Datapath: quantizer pipeline, zigzag store, run accumulator and output register.
// Depends on qzr_pkg; driven by qzr_ctrl through t_dp_cmd.
module qzr_datapath
    import qzr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_status                  o_status,
    input  logic                        i_table_select_we,
    input  logic                        i_table_select,
    input  logic signed [COEF_BITS-1:0] i_coefficient,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic signed [COEF_BITS-1:0] o_run_value,
    output logic [CNT_BITS-1:0]         o_run_count,
    output logic                        o_last
);

    logic [RECIP_BITS-1:0] recip_luma   [BLOCK_LEN];
    logic [RECIP_BITS-1:0] recip_chroma [BLOCK_LEN];

    for (genvar g = 0; g < BLOCK_LEN; g++) begin : g_recip
        localparam longint RL =
            ((longint'(1) << QUANT_SHIFT) + 2 * LUMA_Q[g] - 1) / (2 * LUMA_Q[g]);
        localparam longint RC =
            ((longint'(1) << QUANT_SHIFT) + 2 * CHROMA_Q[g] - 1) / (2 * CHROMA_Q[g]);
        assign recip_luma[g]   = RECIP_BITS'(RL);
        assign recip_chroma[g] = RECIP_BITS'(RC);
    end

    logic                   r_table_select;
    logic                   coef_neg;
    logic [COEF_BITS-1:0]   coef_mag;
    logic [QTAB_BITS-1:0]   divisor;
    logic [RECIP_BITS-1:0]  recip;
    logic [NUM_BITS-1:0]    numerator;

    logic                   r_s1_valid;
    logic                   r_s1_neg;
    logic [POS_BITS-1:0]    r_s1_rank;
    logic [NUM_BITS-1:0]    r_s1_num;
    logic [RECIP_BITS-1:0]  r_s1_recip;

    logic                   r_s2_valid;
    logic                   r_s2_neg;
    logic [POS_BITS-1:0]    r_s2_rank;
    logic [PROD_BITS-1:0]   r_s2_prod;

    logic [QUO_BITS-1:0]    quotient;
    logic [COEF_BITS-1:0]   quot_ext;
    logic [COEF_BITS-1:0]   quant_value;

    logic [COEF_BITS-1:0]   r_mem [BLOCK_LEN];
    logic [COEF_BITS-1:0]   r_rd_data;
    logic [COEF_BITS-1:0]   r_run_val;
    logic [CNT_BITS-1:0]    r_run_cnt;

    logic                   r_out_valid;
    logic [COEF_BITS-1:0]   r_out_value;
    logic [CNT_BITS-1:0]    r_out_count;
    logic                   r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_select <= 1'b0;
        end else if (i_table_select_we) begin
            r_table_select <= i_table_select;
        end
    end

    // Stage 0: magnitude, divisor and reciprocal lookup.
    always_comb begin
        coef_neg  = i_coefficient[COEF_BITS-1];
        coef_mag  = coef_neg ? (~i_coefficient + 1'b1) : i_coefficient;
        divisor   = r_table_select ? QTAB_BITS'(CHROMA_Q[i_cmd.load_pos])
                                   : QTAB_BITS'(LUMA_Q[i_cmd.load_pos]);
        recip     = r_table_select ? recip_chroma[i_cmd.load_pos]
                                   : recip_luma[i_cmd.load_pos];
        numerator = {coef_mag, 1'b0} + NUM_BITS'(divisor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.load;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_neg   <= coef_neg;
        r_s1_rank  <= POS_BITS'(ZZ_RANK[i_cmd.load_pos]);
        r_s1_num   <= numerator;
        r_s1_recip <= recip;
        r_s2_neg   <= r_s1_neg;
        r_s2_rank  <= r_s1_rank;
        r_s2_prod  <= PROD_BITS'(r_s1_num) * PROD_BITS'(r_s1_recip);
    end

    // Stage 2: quotient, sign restore and store write.
    always_comb begin
        quotient    = r_s2_prod[QUANT_SHIFT +: QUO_BITS];
        quot_ext    = COEF_BITS'(quotient);
        quant_value = r_s2_neg ? (~quot_ext + 1'b1) : quot_ext;
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_mem[r_s2_rank] <= quant_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_run_val <= r_rd_data;
            r_run_cnt <= CNT_BITS'(1);
        end else if (i_cmd.run_inc) begin
            r_run_cnt <= r_run_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_value <= r_run_val;
            r_out_count <= r_run_cnt;
            r_out_last  <= i_cmd.emit_last;
        end
    end

    assign o_status.run_match = (r_rd_data == r_run_val);
    assign o_status.out_free  = !r_out_valid || !i_stall;

    assign o_valid     = r_out_valid;
    assign o_run_value = r_out_value;
    assign o_run_count = r_out_count;
    assign o_last      = r_out_last;

endmodule

### hdl/qzr_ctrl.sv
// Controller: sequences block load, pipeline drain and run-length scan.
// Depends on qzr_pkg; commands qzr_datapath through t_dp_cmd.
module qzr_ctrl
    import qzr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state              r_state;
    t_state              n_state;
    logic [POS_BITS-1:0] r_load_pos;
    logic [POS_BITS-1:0] n_load_pos;
    logic [CNT_BITS-1:0] r_rd_addr;
    logic [CNT_BITS-1:0] n_rd_addr;
    logic                r_dv;
    logic                n_dv;
    logic                r_first;
    logic                n_first;

    logic                accept;
    logic                consume;
    logic                issue;
    logic                all_issued;

    // The read-data register holds an entry until it is folded into the run.
    always_comb begin
        accept     = (r_state == ST_LOAD) && i_valid;
        all_issued = r_rd_addr[POS_BITS];
        consume    = (r_state == ST_SCAN) && r_dv &&
                     (r_first || i_status.run_match || i_status.out_free);
        issue      = (r_state == ST_SCAN) && (!r_dv || consume) && !all_issued;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (accept && (r_load_pos == POS_BITS'(BLOCK_LEN - 1))) begin
                    n_state = ST_DRAIN_A;
                end
            end
            ST_DRAIN_A: begin
                n_state = ST_DRAIN_B;
            end
            ST_DRAIN_B: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (consume && all_issued) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (i_status.out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_stall           = 1'b1;
        o_cmd.load        = 1'b0;
        o_cmd.load_pos    = r_load_pos;
        o_cmd.rd_en       = 1'b0;
        o_cmd.rd_addr     = r_rd_addr[POS_BITS-1:0];
        o_cmd.run_start   = 1'b0;
        o_cmd.run_inc     = 1'b0;
        o_cmd.emit        = 1'b0;
        o_cmd.emit_last   = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_stall    = 1'b0;
                o_cmd.load = accept;
            end
            ST_DRAIN_A: begin
                o_stall = 1'b1;
            end
            ST_DRAIN_B: begin
                o_stall = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.rd_en     = issue;
                o_cmd.run_start = consume && (r_first || !i_status.run_match);
                o_cmd.run_inc   = consume && !r_first && i_status.run_match;
                o_cmd.emit      = consume && !r_first && !i_status.run_match;
            end
            ST_FINAL: begin
                o_cmd.emit      = i_status.out_free;
                o_cmd.emit_last = 1'b1;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_load_pos = accept ? (r_load_pos + 1'b1) : r_load_pos;
        if (r_state != ST_SCAN) begin
            n_rd_addr = '0;
            n_dv      = 1'b0;
            n_first   = 1'b1;
        end else begin
            n_rd_addr = issue ? (r_rd_addr + 1'b1) : r_rd_addr;
            n_dv      = issue ? 1'b1 : (consume ? 1'b0 : r_dv);
            n_first   = consume ? 1'b0 : r_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_pos <= '0;
            r_rd_addr  <= '0;
            r_dv       <= 1'b0;
            r_first    <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_load_pos <= n_load_pos;
            r_rd_addr  <= n_rd_addr;
            r_dv       <= n_dv;
            r_first    <= n_first;
        end
    end

endmodule

### hdl/quantize_zigzag_run_length.sv
// Top level of the 8x8 block quantizer, zigzag reorderer and run-length coder.
// Depends on qzr_pkg, qzr_ctrl and qzr_datapath.
//
// The block takes the 64 coefficients of one 8x8 block in row-major order, one
// beat per cycle while o_stall is low, divides each by the luminance or
// chrominance quantization table entry at its position (rounded to nearest,
// ties away from zero, exact), and writes the result into a 64-entry store at
// its zigzag rank. After the 64th coefficient the input stalls while the
// quantizer pipeline drains (ST_DRAIN_A, ST_DRAIN_B), then the store is read
// one entry per cycle, unless an entry that ends a run must wait for a stalled
// output, and each run of equal neighbors leaves as one output beat of value and
// count; the final run of the block carries o_last. Input beats are taken again
// as soon as that final run sits in the output register. A block passes through
// the load, drain, scan and final-emit phases in that order, and the input stays
// stalled through all but the load phase.
// Block throughput is set by the single read port of the zigzag store during
// the scan and by one coefficient per cycle through the quantizer multiplier.
// The table select register is sampled as each coefficient arrives, so it
// should only be written between blocks unless a mixed block is wanted.
module quantize_zigzag_run_length
    import qzr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_table_select_we,
    input  logic                        i_table_select,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [COEF_BITS-1:0] i_coefficient,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [COEF_BITS-1:0] o_run_value,
    output logic [CNT_BITS-1:0]         o_run_count,
    output logic                        o_last
);

    // Commands flow from the controller to the datapath; status flows back.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    qzr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    qzr_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_table_select_we (i_table_select_we),
        .i_table_select    (i_table_select),
        .i_coefficient     (i_coefficient),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_run_value       (o_run_value),
        .o_run_count       (o_run_count),
        .o_last            (o_last)
    );

endmodule

### hdl/qzr_checker.sv
// Port-level checker for quantize_zigzag_run_length, attached by bind.
// Depends on qzr_pkg.
module qzr_checker
    import qzr_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_table_select_we,
    input logic                        i_table_select,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic signed [COEF_BITS-1:0] i_coefficient,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic signed [COEF_BITS-1:0] o_run_value,
    input logic [CNT_BITS-1:0]         o_run_count,
    input logic                        o_last
);

    logic                 in_beat;
    logic                 out_beat;
    logic [POS_BITS-1:0]  r_in_cnt;
    logic                 r_pending;
    logic [CNT_BITS:0]    r_sum;
    logic [CNT_BITS:0]    sum_now;
    logic                 r_have_prev;
    logic [COEF_BITS-1:0] r_prev_val;

    assign in_beat  = i_valid && !o_stall;
    assign out_beat = o_valid && !i_stall;
    assign sum_now  = r_sum + (CNT_BITS + 1)'(o_run_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt    <= '0;
            r_pending   <= 1'b0;
            r_sum       <= '0;
            r_have_prev <= 1'b0;
        end else begin
            if (in_beat) begin
                r_in_cnt <= r_in_cnt + 1'b1;
            end
            if (in_beat && (r_in_cnt == POS_BITS'(BLOCK_LEN - 1))) begin
                r_pending <= 1'b1;
            end else if (o_valid && o_last) begin
                r_pending <= 1'b0;
            end
            if (out_beat) begin
                r_sum       <= o_last ? '0 : sum_now;
                r_have_prev <= !o_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_beat) begin
            r_prev_val <= o_run_value;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_run_value) &&
            $stable(o_run_count) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_runs_cover_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> (o_last ? (sum_now == (CNT_BITS + 1)'(BLOCK_LEN))
                             : (sum_now < (CNT_BITS + 1)'(BLOCK_LEN))))
        else $error("run counts of a block do not add up to the block length");

    a_runs_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_have_prev |-> o_run_value != r_prev_val)
        else $error("two neighboring runs carry the same value");

    a_no_load_during_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending && !(o_valid && o_last) |-> o_stall)
        else $error("input taken before the final run of the block was produced");

endmodule

bind quantize_zigzag_run_length qzr_checker u_qzr_checker (.*);
